@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("allocator assertion failed");

`endif

@@ design/ffba_pkg.sv @@
// Shared types and constants of the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [SIZE_W-1:0] ALIGN_MASK = 32'd7;
  localparam logic [ADDR_W-1:0] BASE_RESET = 48'h20_0000;

  typedef enum logic [2:0] {
    ST_REUSED    = 3'd0,
    ST_NEW       = 3'd1,
    ST_FREED     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_ZERO      = 3'd4,
    ST_NO_ROOM   = 3'd5
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } key_t;

endpackage

@@ design/ffba_if.sv @@
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps

interface ffba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [ffba_pkg::SIZE_W-1:0]   request_bytes;
  logic [ffba_pkg::ADDR_W-1:0]   release_address;

  modport source (output valid, op, request_bytes, release_address, input ready);
  modport sink   (input valid, op, request_bytes, release_address, output ready);
endinterface

interface ffba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffba_pkg::ADDR_W-1:0]   granted_address;
  logic [2:0]                    status;

  modport source (output valid, granted_address, status, input ready);
  modport sink   (input valid, granted_address, status, output ready);
endinterface

@@ design/ffba_table.sv @@
// Descriptor memory: one write port and one registered read port.
`timescale 1ns / 1ps

module ffba_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_idx_i,
  output ffba_pkg::entry_t           rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_idx_i,
  input  ffba_pkg::entry_t           wr_data_i
);

  ffba_pkg::entry_t mem_q [DEPTH];
  ffba_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/ffba_match.sv @@
// Shared compare unit: first-fit size test or exact address match.
`timescale 1ns / 1ps

module ffba_match (
  input  ffba_pkg::key_t   key_i,
  input  ffba_pkg::entry_t entry_i,
  output logic             hit_o
);

  always_comb begin
    if (key_i.op == ffba_pkg::OP_FREE) begin
      hit_o = (entry_i.addr == key_i.addr);
    end else begin
      hit_o = entry_i.free && (entry_i.size >= key_i.size);
    end
  end

endmodule

@@ design/ffba_seq.sv @@
// Request sequencer: descriptor scan, append arithmetic and result register.
`timescale 1ns / 1ps

module ffba_seq #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ffba_pkg::ADDR_W-1:0]     cfg_wdata_i,
  ffba_req_if.sink                        req_i,
  ffba_rsp_if.source                      rsp_o,
  output logic                            rd_en_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]   rd_idx_o,
  input  ffba_pkg::entry_t                rd_data_i,
  output logic                            wr_en_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]   wr_idx_o,
  output ffba_pkg::entry_t                wr_data_o,
  output ffba_pkg::key_t                  key_o,
  input  logic                            hit_i
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = ffba_pkg::ADDR_W;
  localparam int unsigned SW = ffba_pkg::SIZE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APP_A,
    S_APP_B,
    S_RESP
  } state_e;

  state_e                 state_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          issue_q;
  logic [IW-1:0]          chk_q;
  logic                   rd_vld_q;
  logic [AW-1:0]          heap_next_q;
  ffba_pkg::key_t         key_q;
  logic [AW:0]            data_q;
  ffba_pkg::status_e      res_status_q;
  logic [AW-1:0]          res_addr_q;
  logic                   wr_en_q;
  logic [IW-1:0]          wr_idx_q;
  ffba_pkg::entry_t       wr_data_q;
  logic                   out_vld_q;
  logic [AW-1:0]          out_addr_q;
  ffba_pkg::status_e      out_status_q;

  logic [SW:0]            round_sum;
  logic [SW-1:0]          round_size;
  logic                   hit_now;
  logic                   more;
  logic [AW+1:0]          end_sum;

  assign round_sum  = {1'b0, req_i.request_bytes} + {1'b0, ffba_pkg::ALIGN_MASK};
  assign round_size = round_sum[SW-1:0] & ~ffba_pkg::ALIGN_MASK;
  assign hit_now    = rd_vld_q && hit_i;
  assign more       = (issue_q < count_q);
  assign end_sum    = {1'b0, data_q} + {{(AW+2-SW){1'b0}}, key_q.size};

  assign rd_en_o   = (state_q == S_SCAN) && more && !hit_now;
  assign rd_idx_o  = issue_q[IW-1:0];
  assign wr_en_o   = wr_en_q;
  assign wr_idx_o  = wr_idx_q;
  assign wr_data_o = wr_data_q;
  assign key_o     = key_q;

  assign req_i.ready           = (state_q == S_IDLE);
  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.granted_address = out_addr_q;
  assign rsp_o.status          = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      chk_q       <= '0;
      rd_vld_q    <= 1'b0;
      heap_next_q <= ffba_pkg::BASE_RESET;
      wr_en_q     <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      wr_en_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (count_q == '0) begin
          heap_next_q <= cfg_wdata_i;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            key_q      <= '{op: req_i.op, size: round_size, addr: req_i.release_address};
            res_addr_q <= '0;
            issue_q    <= '0;
            if (req_i.op == ffba_pkg::OP_ALLOC && req_i.request_bytes == '0) begin
              res_status_q <= ffba_pkg::ST_ZERO;
              state_q      <= S_RESP;
            end else if (req_i.op == ffba_pkg::OP_ALLOC && round_sum[SW]) begin
              res_status_q <= ffba_pkg::ST_NO_ROOM;
              state_q      <= S_RESP;
            end else if (req_i.op == ffba_pkg::OP_FREE && req_i.release_address == '0) begin
              res_status_q <= ffba_pkg::ST_NOT_FOUND;
              state_q      <= S_RESP;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (hit_now) begin
            // Write the hit descriptor back with its new free flag.
            wr_en_q   <= 1'b1;
            wr_idx_q  <= chk_q;
            wr_data_q <= '{addr: rd_data_i.addr, size: rd_data_i.size,
                           free: (key_q.op == ffba_pkg::OP_FREE)};
            if (key_q.op == ffba_pkg::OP_FREE) begin
              res_status_q <= ffba_pkg::ST_FREED;
            end else begin
              res_addr_q   <= rd_data_i.addr;
              res_status_q <= ffba_pkg::ST_REUSED;
            end
            state_q <= S_RESP;
          end else if (more) begin
            rd_vld_q <= 1'b1;
            chk_q    <= issue_q[IW-1:0];
            issue_q  <= issue_q + 1'b1;
          end else if (key_q.op == ffba_pkg::OP_FREE) begin
            res_status_q <= ffba_pkg::ST_NOT_FOUND;
            state_q      <= S_RESP;
          end else begin
            state_q <= S_APP_A;
          end
        end

        S_APP_A: begin
          if (count_q >= CW'(MAX_BLOCKS)) begin
            res_status_q <= ffba_pkg::ST_NO_ROOM;
            state_q      <= S_RESP;
          end else begin
            data_q  <= {1'b0, heap_next_q} + (AW+1)'(HEADER_BYTES);
            state_q <= S_APP_B;
          end
        end

        S_APP_B: begin
          if (end_sum[AW+1:AW] != 2'b00) begin
            res_status_q <= ffba_pkg::ST_NO_ROOM;
          end else begin
            wr_en_q      <= 1'b1;
            wr_idx_q     <= count_q[IW-1:0];
            wr_data_q    <= '{addr: data_q[AW-1:0], size: key_q.size, free: 1'b0};
            count_q      <= count_q + 1'b1;
            heap_next_q  <= end_sum[AW-1:0];
            res_addr_q   <= data_q[AW-1:0];
            res_status_q <= ffba_pkg::ST_NEW;
          end
          state_q <= S_RESP;
        end

        S_RESP: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q    <= 1'b1;
            out_addr_q   <= res_addr_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/first_fit_block_allocator_top.sv @@
// Top level of the first-fit block allocator.
`timescale 1ns / 1ps

// The allocator keeps up to MAX_BLOCKS block descriptors (data address, size,
// free flag) in creation order in a single-port-read memory. An allocate word
// rounds its size up to a multiple of 8 bytes and reuses the first free
// descriptor that is large enough, without splitting it; when none fits, a new
// descriptor is appended at the bump pointer, past a header of HEADER_BYTES,
// and the pointer advances. A free word marks the descriptor with exactly that
// data address as free. Each request word produces exactly one response word
// carrying the granted address (zero unless a block was granted) and a status
// code. Timing: the block takes one request at a time and drops ready from
// acceptance until the result is in the output register. The descriptor scan
// reads one entry of the table memory per cycle; a new block adds the append
// arithmetic after the scan, and a zero size, an oversized request or a free
// of address zero goes straight to the result without a scan. The output
// register lets the next request be accepted while a response word still
// waits. Writing heap_base (cfg_we_i) moves the bump pointer, but only while
// the table is empty; configuration must be written only while the block is
// idle, which the block itself does not enforce. The descriptor memory needs
// no clearing pass: only entries below the fill count are ever read.

module first_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffba_pkg::ADDR_W-1:0]   cfg_wdata_i,
  ffba_req_if.sink                      req_i,
  ffba_rsp_if.source                    rsp_o
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);

  // Table memory ports driven by the sequencer.
  logic              rd_en;
  logic [IW-1:0]     rd_idx;
  ffba_pkg::entry_t  rd_data;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  ffba_pkg::entry_t  wr_data;

  // The compare unit sees the held request key and the registered read data.
  ffba_pkg::key_t    key;
  logic              hit;

  ffba_seq #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rd_en_o     (rd_en),
    .rd_idx_o    (rd_idx),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_idx_o    (wr_idx),
    .wr_data_o   (wr_data),
    .key_o       (key),
    .hit_i       (hit)
  );

  ffba_table #(
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data)
  );

  ffba_match u_match (
    .key_i   (key),
    .entry_i (rd_data),
    .hit_o   (hit)
  );

endmodule

@@ design/ffba_checker.sv @@
// Port-level assertions of the allocator and their bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [ffba_pkg::ADDR_W-1:0]  granted_address_i,
  input logic [2:0]                   status_i
);

  // A response word waits until it is taken.
  `FFBA_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)

  // A stalled response word keeps its payload.
  `FFBA_ASSERT_NXT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, $stable(granted_address_i) && $stable(status_i))

  // One request at a time: the block is busy right after an acceptance.
  `FFBA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // Only a granted block carries a nonzero address.
  `FFBA_ASSERT_IMP(a_addr_zero, clk_i, rst_ni, rsp_valid_i && status_i != ffba_pkg::ST_REUSED && status_i != ffba_pkg::ST_NEW, granted_address_i == '0)

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .granted_address_i (rsp_o.granted_address),
  .status_i          (rsp_o.status)
);
